FILE: hw/rtl/bvm_pkg.sv
// Shared types, constants and codes for the battery voltage monitor.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps
`default_nettype none

package bvm_pkg;

   // Field widths
   localparam int ADC_BITS_DEF = 12;
   localparam int VOLT_W       = 14;
   localparam int CELLS_W      = 4;
   localparam int LEVEL_W      = 9;
   localparam int CELL_V_W     = 6;
   localparam int REG8_W       = 8;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 8;

   // Conversion constants
   localparam int VREF_FACTOR  = 33;
   localparam int ROUND_FACTOR = 5;
   localparam int HYST         = 1;

   localparam logic [VOLT_W-1:0]  PRESENT_LEVEL = VOLT_W'(10);
   localparam logic [CELLS_W-1:0] MAX_CELLS     = CELLS_W'(8);
   localparam logic [CELLS_W-1:0] CELLS_RESET   = CELLS_W'(1);
   localparam logic [LEVEL_W-1:0] LEVEL_MAX     = '1;

   // Register reset values
   localparam logic [REG8_W-1:0]   SCALE_RESET     = REG8_W'(110);
   localparam logic [REG8_W-1:0]   DIV_VAL_RESET   = REG8_W'(10);
   localparam logic [REG8_W-1:0]   DIV_MULT_RESET  = REG8_W'(1);
   localparam logic [CELL_V_W-1:0] CELL_MAX_RESET  = CELL_V_W'(43);
   localparam logic [CELL_V_W-1:0] CELL_WARN_RESET = CELL_V_W'(35);
   localparam logic [CELL_V_W-1:0] CELL_MIN_RESET  = CELL_V_W'(33);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VOLTAGE_SCALE        = 3'd0,
      CSR_DIVIDER_VALUE        = 3'd1,
      CSR_DIVIDER_MULTIPLIER   = 3'd2,
      CSR_CELL_MAX_VOLTAGE     = 3'd3,
      CSR_CELL_WARNING_VOLTAGE = 3'd4,
      CSR_CELL_MIN_VOLTAGE     = 3'd5
   } csr_idx_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_WARN   = 2'd1,
      ST_CRIT   = 2'd2,
      ST_ABSENT = 2'd3
   } bat_status_type;

   typedef enum logic [1:0] {
      BEEP_NONE = 2'd0,
      BEEP_LOW  = 2'd1,
      BEEP_CRIT = 2'd2
   } beep_type;

   typedef enum logic [1:0] {
      DIV_CONV = 2'd0,  // scaled sample over full scale times divider value
      DIV_MULT = 2'd1,  // by divider multiplier
      DIV_CELL = 2'd2   // raw voltage by full cell voltage
   } div_op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL_LO,
      S_MUL_HI,
      S_CONV_GO,
      S_CONV_RUN,
      S_MULT_GO,
      S_MULT_RUN,
      S_CHECK,
      S_CELL_GO,
      S_CELL_RUN,
      S_CELLS,
      S_UPDATE
   } bvm_state_type;

   typedef struct packed {
      logic       capture;
      logic       sel_raw;
      logic       mul_lo;
      logic       mul_hi;
      logic       div_start;
      div_op_type div_op;
      logic       save_volt;
      logic       save_cells;
      logic       commit;
   } bvm_cmd_type;

   typedef struct packed {
      logic div_done;
      logic connect;
      logic cell_max_zero;
      logic out_full;
   } bvm_status_type;

endpackage

`default_nettype wire

FILE: hw/rtl/bvm_if.sv
// Channel interfaces of the battery voltage monitor: request, response, register write.
// Depends on bvm_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bvm_req_if #(parameter int ADC_BITS = bvm_pkg::ADC_BITS_DEF);
   logic                valid;
   logic                ready;
   logic [ADC_BITS-1:0] filtered_sample;
   logic [ADC_BITS-1:0] raw_sample;

   modport source (output valid, filtered_sample, raw_sample, input ready);
   modport sink   (input valid, filtered_sample, raw_sample, output ready);
endinterface

interface bvm_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [bvm_pkg::VOLT_W-1:0]   voltage;
   logic [1:0]                   battery_status;
   logic [bvm_pkg::CELLS_W-1:0]  cells;
   logic [bvm_pkg::LEVEL_W-1:0]  warning_threshold;
   logic [bvm_pkg::LEVEL_W-1:0]  critical_threshold;
   logic [1:0]                   beep_request;

   modport source (output valid, voltage, battery_status, cells, warning_threshold,
                   critical_threshold, beep_request, input ready);
   modport sink   (input valid, voltage, battery_status, cells, warning_threshold,
                   critical_threshold, beep_request, output ready);
endinterface

interface bvm_csr_if;
   logic                           valid;
   logic                           ready;
   logic [bvm_pkg::CSR_IDX_W-1:0]  index;
   logic [bvm_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/bvm_divider.sv
// Restoring serial divider, one quotient bit per cycle, 14-bit quotient.
// Depends on bvm_pkg; the dividend's upper part must be below the divisor.
`timescale 1ns / 1ps
`default_nettype none

module bvm_divider #(
   parameter int NUM_W = bvm_pkg::ADC_BITS_DEF + bvm_pkg::VOLT_W,
   parameter int DEN_W = bvm_pkg::ADC_BITS_DEF + bvm_pkg::REG8_W
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [NUM_W-1:0]           dividend,
   input  logic [DEN_W-1:0]           divisor,
   output logic [bvm_pkg::VOLT_W-1:0] quotient,
   output logic                       done
);
   import bvm_pkg::*;

   localparam int CNT_W = $clog2(VOLT_W + 1);

   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [VOLT_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              done_ff, done_in;

   logic [DEN_W:0] trial;
   logic [DEN_W:0] diff;
   logic           fits;

   assign trial = {rem_ff, quo_ff[VOLT_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = (trial >= {1'b0, den_ff});

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         // upper dividend bits seed the partial remainder
         rem_in = DEN_W'(dividend[NUM_W-1:VOLT_W]);
         den_in = divisor;
         quo_in = dividend[VOLT_W-1:0];
         cnt_in = CNT_W'(VOLT_W);
      end else if (cnt_ff != '0) begin
         rem_in  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in  = {quo_ff[VOLT_W-2:0], fits};
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/bvm_datapath.sv
// Datapath: configuration registers, scaling multipliers, divider, battery state
// and the response register. Depends on bvm_pkg and bvm_divider.
`timescale 1ns / 1ps
`default_nettype none

module bvm_datapath #(
   parameter int ADC_BITS = bvm_pkg::ADC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  bvm_pkg::bvm_cmd_type           cmd,
   output bvm_pkg::bvm_status_type        status,
   input  logic [ADC_BITS-1:0]            filtered_sample,
   input  logic [ADC_BITS-1:0]            raw_sample,
   input  logic                           csr_valid,
   input  logic [bvm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bvm_pkg::CSR_DATA_W-1:0] csr_data,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [bvm_pkg::VOLT_W-1:0]     voltage,
   output logic [1:0]                     battery_status,
   output logic [bvm_pkg::CELLS_W-1:0]    cells,
   output logic [bvm_pkg::LEVEL_W-1:0]    warning_threshold,
   output logic [bvm_pkg::LEVEL_W-1:0]    critical_threshold,
   output logic [1:0]                     beep_request
);
   import bvm_pkg::*;

   localparam int PROD_W = ADC_BITS + REG8_W;
   localparam int NUM_W  = ADC_BITS + VOLT_W;
   localparam int DEN_W  = ADC_BITS + REG8_W;
   localparam int LPROD_W = CELLS_W + CELL_V_W;
   localparam int CMP_W  = VOLT_W + 1;
   localparam logic [ADC_BITS-1:0] FULL_SCALE = '1;
   localparam logic [NUM_W-1:0] ROUND_TERM = NUM_W'((2 ** ADC_BITS - 1) * ROUND_FACTOR);

   function automatic logic [LEVEL_W-1:0] sat_level(input logic [LPROD_W-1:0] x);
      logic [LEVEL_W-1:0] r;
      r = (x > LPROD_W'(LEVEL_MAX)) ? LEVEL_MAX : x[LEVEL_W-1:0];
      return r;
   endfunction

   // configuration
   logic [REG8_W-1:0]   scale_ff, scale_in;
   logic [REG8_W-1:0]   div_val_ff, div_val_in;
   logic [REG8_W-1:0]   div_mult_ff, div_mult_in;
   logic [CELL_V_W-1:0] cell_max_ff, cell_max_in;
   logic [CELL_V_W-1:0] cell_warn_ff, cell_warn_in;
   logic [CELL_V_W-1:0] cell_min_ff, cell_min_in;

   // working registers
   logic [ADC_BITS-1:0] filt_ff, filt_in;
   logic [ADC_BITS-1:0] raw_ff, raw_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [NUM_W-1:0]    num_ff, num_in;
   logic [VOLT_W-1:0]   volt_ff, volt_in;
   logic [CELLS_W-1:0]  cand_cells_ff, cand_cells_in;
   logic [LEVEL_W-1:0]  cand_wl_ff, cand_wl_in;
   logic [LEVEL_W-1:0]  cand_cl_ff, cand_cl_in;

   // battery state
   bat_status_type     mon_state_ff, mon_state_in;
   logic [CELLS_W-1:0] cells_ff, cells_in;
   logic [LEVEL_W-1:0] wl_ff, wl_in;
   logic [LEVEL_W-1:0] cl_ff, cl_in;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VOLT_W-1:0]  rsp_volt_ff, rsp_volt_in;
   bat_status_type     rsp_stat_ff, rsp_stat_in;
   logic [CELLS_W-1:0] rsp_cells_ff, rsp_cells_in;
   logic [LEVEL_W-1:0] rsp_wl_ff, rsp_wl_in;
   logic [LEVEL_W-1:0] rsp_cl_ff, rsp_cl_in;
   beep_type           rsp_beep_ff, rsp_beep_in;

   // divider hookup
   logic [NUM_W-1:0]  div_dividend;
   logic [DEN_W-1:0]  div_divisor;
   logic [VOLT_W-1:0] div_q;
   logic              div_done;
   logic [REG8_W-1:0] dv_eff;
   logic [REG8_W-1:0] dm_eff;

   // cell count and levels
   logic [CMP_W-1:0]   cell_sum;
   logic [CELLS_W-1:0] cells_calc;

   // state update
   bat_status_type     st_mid;
   bat_status_type     st_new;
   beep_type           beep_new;
   logic [CELLS_W-1:0] cells_new;
   logic [LEVEL_W-1:0] wl_new;
   logic [LEVEL_W-1:0] cl_new;
   logic [CMP_W-1:0]   v_ext;
   logic [CMP_W-1:0]   v_hyst;
   logic [CMP_W-1:0]   wl_ext;
   logic [CMP_W-1:0]   cl_ext;

   // register writes
   always_comb begin
      scale_in     = scale_ff;
      div_val_in   = div_val_ff;
      div_mult_in  = div_mult_ff;
      cell_max_in  = cell_max_ff;
      cell_warn_in = cell_warn_ff;
      cell_min_in  = cell_min_ff;
      if (csr_valid) begin
         unique case (csr_idx_type'(csr_index))
            CSR_VOLTAGE_SCALE:        scale_in     = csr_data[REG8_W-1:0];
            CSR_DIVIDER_VALUE:        div_val_in   = csr_data[REG8_W-1:0];
            CSR_DIVIDER_MULTIPLIER:   div_mult_in  = csr_data[REG8_W-1:0];
            CSR_CELL_MAX_VOLTAGE:     cell_max_in  = csr_data[CELL_V_W-1:0];
            CSR_CELL_WARNING_VOLTAGE: cell_warn_in = csr_data[CELL_V_W-1:0];
            CSR_CELL_MIN_VOLTAGE:     cell_min_in  = csr_data[CELL_V_W-1:0];
            default: ;
         endcase
      end
   end

   // a zero divisor register acts as one
   assign dv_eff = (div_val_ff == '0) ? REG8_W'(1) : div_val_ff;
   assign dm_eff = (div_mult_ff == '0) ? REG8_W'(1) : div_mult_ff;

   // capture and scale
   always_comb begin
      filt_in = cmd.capture ? filtered_sample : filt_ff;
      raw_in  = cmd.capture ? raw_sample : raw_ff;
      prod_in = prod_ff;
      if (cmd.mul_lo) begin
         prod_in = PROD_W'(cmd.sel_raw ? raw_ff : filt_ff) * PROD_W'(scale_ff);
      end
      num_in = num_ff;
      if (cmd.mul_hi) begin
         num_in = NUM_W'(prod_ff) * NUM_W'(VREF_FACTOR) + ROUND_TERM;
      end
   end

   always_comb begin
      unique case (cmd.div_op)
         DIV_CONV: begin
            div_dividend = num_ff;
            div_divisor  = DEN_W'(FULL_SCALE) * DEN_W'(dv_eff);
         end
         DIV_MULT: begin
            div_dividend = NUM_W'(div_q);
            div_divisor  = DEN_W'(dm_eff);
         end
         DIV_CELL: begin
            div_dividend = NUM_W'(div_q);
            div_divisor  = DEN_W'(cell_max_ff);
         end
         default: begin
            div_dividend = num_ff;
            div_divisor  = DEN_W'(dm_eff);
         end
      endcase
   end

   bvm_divider #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_q),
      .done     (div_done)
   );

   // cell count from raw voltage, clamped; levels saturate at the field maximum
   assign cell_sum = CMP_W'(div_q) + CMP_W'(1);

   always_comb begin
      if (cell_max_ff == '0) begin
         cells_calc = MAX_CELLS;
      end else if (cell_sum > CMP_W'(MAX_CELLS)) begin
         cells_calc = MAX_CELLS;
      end else begin
         cells_calc = cell_sum[CELLS_W-1:0];
      end
      volt_in       = cmd.save_volt ? div_q : volt_ff;
      cand_cells_in = cand_cells_ff;
      cand_wl_in    = cand_wl_ff;
      cand_cl_in    = cand_cl_ff;
      if (cmd.save_cells) begin
         cand_cells_in = cells_calc;
         cand_wl_in    = sat_level(LPROD_W'(cells_calc) * LPROD_W'(cell_warn_ff));
         cand_cl_in    = sat_level(LPROD_W'(cells_calc) * LPROD_W'(cell_min_ff));
      end
   end

   // presence, then warning/critical with hysteresis
   always_comb begin
      st_mid    = mon_state_ff;
      cells_new = cells_ff;
      wl_new    = wl_ff;
      cl_new    = cl_ff;
      if (mon_state_ff == ST_ABSENT && volt_ff > PRESENT_LEVEL) begin
         st_mid    = ST_OK;
         cells_new = cand_cells_ff;
         wl_new    = cand_wl_ff;
         cl_new    = cand_cl_ff;
      end else if (mon_state_ff != ST_ABSENT && volt_ff <= PRESENT_LEVEL) begin
         st_mid    = ST_ABSENT;
         cells_new = '0;
         wl_new    = '0;
         cl_new    = '0;
      end

      v_ext  = CMP_W'(volt_ff);
      v_hyst = CMP_W'(volt_ff) + CMP_W'(HYST);
      wl_ext = CMP_W'(wl_new);
      cl_ext = CMP_W'(cl_new);

      st_new   = st_mid;
      beep_new = BEEP_NONE;
      unique case (st_mid)
         ST_OK: begin
            if (v_hyst <= wl_ext) begin
               st_new   = ST_WARN;
               beep_new = BEEP_LOW;
            end
         end
         ST_WARN: begin
            if (v_hyst <= cl_ext) begin
               st_new   = ST_CRIT;
               beep_new = BEEP_CRIT;
            end else if (v_ext > wl_ext + CMP_W'(HYST)) begin
               st_new = ST_OK;
            end else begin
               beep_new = BEEP_LOW;
            end
         end
         ST_CRIT: begin
            if (v_ext > cl_ext + CMP_W'(HYST)) begin
               st_new   = ST_WARN;
               beep_new = BEEP_LOW;
            end else begin
               beep_new = BEEP_CRIT;
            end
         end
         ST_ABSENT: ;
      endcase
   end

   always_comb begin
      mon_state_in = mon_state_ff;
      cells_in     = cells_ff;
      wl_in        = wl_ff;
      cl_in        = cl_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_volt_in  = rsp_volt_ff;
      rsp_stat_in  = rsp_stat_ff;
      rsp_cells_in = rsp_cells_ff;
      rsp_wl_in    = rsp_wl_ff;
      rsp_cl_in    = rsp_cl_ff;
      rsp_beep_in  = rsp_beep_ff;
      if (cmd.commit) begin
         mon_state_in = st_new;
         cells_in     = cells_new;
         wl_in        = wl_new;
         cl_in        = cl_new;
         rsp_valid_in = 1'b1;
         rsp_volt_in  = volt_ff;
         rsp_stat_in  = st_new;
         rsp_cells_in = cells_new;
         rsp_wl_in    = wl_new;
         rsp_cl_in    = cl_new;
         rsp_beep_in  = beep_new;
      end
   end

   always_ff @(posedge clock) begin
      filt_ff       <= filt_in;
      raw_ff        <= raw_in;
      prod_ff       <= prod_in;
      num_ff        <= num_in;
      volt_ff       <= volt_in;
      cand_cells_ff <= cand_cells_in;
      cand_wl_ff    <= cand_wl_in;
      cand_cl_ff    <= cand_cl_in;
      rsp_volt_ff   <= rsp_volt_in;
      rsp_stat_ff   <= rsp_stat_in;
      rsp_cells_ff  <= rsp_cells_in;
      rsp_wl_ff     <= rsp_wl_in;
      rsp_cl_ff     <= rsp_cl_in;
      rsp_beep_ff   <= rsp_beep_in;
      if (reset) begin
         scale_ff     <= SCALE_RESET;
         div_val_ff   <= DIV_VAL_RESET;
         div_mult_ff  <= DIV_MULT_RESET;
         cell_max_ff  <= CELL_MAX_RESET;
         cell_warn_ff <= CELL_WARN_RESET;
         cell_min_ff  <= CELL_MIN_RESET;
         mon_state_ff <= ST_ABSENT;
         cells_ff     <= CELLS_RESET;
         wl_ff        <= '0;
         cl_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         scale_ff     <= scale_in;
         div_val_ff   <= div_val_in;
         div_mult_ff  <= div_mult_in;
         cell_max_ff  <= cell_max_in;
         cell_warn_ff <= cell_warn_in;
         cell_min_ff  <= cell_min_in;
         mon_state_ff <= mon_state_in;
         cells_ff     <= cells_in;
         wl_ff        <= wl_in;
         cl_ff        <= cl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.div_done      = div_done;
   assign status.connect       = (mon_state_ff == ST_ABSENT) && (div_q > PRESENT_LEVEL);
   assign status.cell_max_zero = (cell_max_ff == '0);
   assign status.out_full      = rsp_valid_ff && !rsp_ready;

   assign rsp_valid          = rsp_valid_ff;
   assign voltage            = rsp_volt_ff;
   assign battery_status     = rsp_stat_ff;
   assign cells              = rsp_cells_ff;
   assign warning_threshold  = rsp_wl_ff;
   assign critical_threshold = rsp_cl_ff;
   assign beep_request       = rsp_beep_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/bvm_ctrl.sv
// Sequencer for the battery voltage monitor: steps the datapath through scaling,
// division and state update for each transaction. Depends on bvm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bvm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  bvm_pkg::bvm_status_type status,
   output bvm_pkg::bvm_cmd_type    cmd
);
   import bvm_pkg::*;

   bvm_state_type state_ff, state_in;
   logic          raw_pass_ff, raw_pass_in;

   // next state
   always_comb begin
      state_in    = state_ff;
      raw_pass_in = raw_pass_ff;
      unique case (state_ff)
         S_IDLE: begin
            raw_pass_in = 1'b0;
            if (req_valid) state_in = S_MUL_LO;
         end
         S_MUL_LO:  state_in = S_MUL_HI;
         S_MUL_HI:  state_in = S_CONV_GO;
         S_CONV_GO: state_in = S_CONV_RUN;
         S_CONV_RUN: begin
            if (status.div_done) state_in = S_MULT_GO;
         end
         S_MULT_GO: state_in = S_MULT_RUN;
         S_MULT_RUN: begin
            if (status.div_done) begin
               if (!raw_pass_ff) begin
                  state_in = S_CHECK;
               end else if (status.cell_max_zero) begin
                  state_in = S_CELLS;
               end else begin
                  state_in = S_CELL_GO;
               end
            end
         end
         S_CHECK: begin
            if (status.connect) begin
               raw_pass_in = 1'b1;
               state_in    = S_MUL_LO;
            end else begin
               state_in = S_UPDATE;
            end
         end
         S_CELL_GO: state_in = S_CELL_RUN;
         S_CELL_RUN: begin
            if (status.div_done) state_in = S_CELLS;
         end
         S_CELLS: state_in = S_UPDATE;
         S_UPDATE: begin
            if (!status.out_full) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      cmd.div_op = DIV_CONV;
      req_ready  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         S_MUL_LO: begin
            cmd.mul_lo  = 1'b1;
            cmd.sel_raw = raw_pass_ff;
         end
         S_MUL_HI: cmd.mul_hi = 1'b1;
         S_CONV_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = DIV_CONV;
         end
         S_MULT_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = DIV_MULT;
         end
         S_CELL_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = DIV_CELL;
         end
         S_CHECK:  cmd.save_volt  = 1'b1;
         S_CELLS:  cmd.save_cells = 1'b1;
         S_UPDATE: cmd.commit     = !status.out_full;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         raw_pass_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         raw_pass_ff <= raw_pass_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/battery_voltage_monitor_unit.sv
// Battery voltage monitor, top level: channel ports, sequencer and datapath.
// Depends on bvm_pkg, bvm_if, bvm_ctrl and bvm_datapath.
//
// Each request transaction carries a filtered and a raw ADC sample. The
// filtered sample becomes a voltage in 0.1 V steps, rounded:
// (sample * scale * 33 + full * 5) / (full * divider_value), then divided
// by divider_multiplier, where full is the ADC full-scale code. A battery
// is present once that voltage is above 1.0 V; on connection the raw sample
// is converted the same way and divided by the full cell voltage to give
// the cell count (plus one, at most eight), from which the pack warning
// and critical levels follow, saturating at 511. Warning and critical
// states switch with one step of hysteresis; a level of zero never trips.
// Every request gives exactly one response with voltage, status, cells,
// both levels and a beep request (low while in warning, critical while
// critical). One transaction is handled at a time; the next request is
// taken once the sequencer is back in idle. The transaction that detects
// a connection runs longer, since it also scales and divides the raw
// sample. The run time is set by the shared serial divider, which yields
// one quotient bit per clock: two divisions per transaction, three more on
// connection (two when the full cell voltage is zero). The response sits
// in an output register, so a new request is taken while the previous
// response still waits; the sequencer only holds at its final step while
// that register is full. Register writes are always ready and should be
// issued only while no transaction is in flight. Reset is synchronous and
// active high.
`timescale 1ns / 1ps
`default_nettype none

module battery_voltage_monitor_unit #(
   parameter int ADC_BITS = bvm_pkg::ADC_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   bvm_req_if.sink   req_chan,
   bvm_rsp_if.source rsp_chan,
   bvm_csr_if.sink   csr_chan
);
   import bvm_pkg::*;

   bvm_cmd_type    cmd;
   bvm_status_type status;

   // register writes never stall
   assign csr_chan.ready = 1'b1;

   // sequencer: accepts a request only when idle, then walks the datapath
   bvm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: holds config, scaling, divider, battery state and response
   bvm_datapath #(
      .ADC_BITS (ADC_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .filtered_sample    (req_chan.filtered_sample),
      .raw_sample         (req_chan.raw_sample),
      .csr_valid          (csr_chan.valid),
      .csr_index          (csr_chan.index),
      .csr_data           (csr_chan.data),
      .rsp_ready          (rsp_chan.ready),
      .rsp_valid          (rsp_chan.valid),
      .voltage            (rsp_chan.voltage),
      .battery_status     (rsp_chan.battery_status),
      .cells              (rsp_chan.cells),
      .warning_threshold  (rsp_chan.warning_threshold),
      .critical_threshold (rsp_chan.critical_threshold),
      .beep_request       (rsp_chan.beep_request)
   );

endmodule

`default_nettype wire

FILE: test/battery_voltage_monitor_unit_test.sv
// Self-checking bench for battery_voltage_monitor_unit: a directed table and then random
// samples over several register settings, each response checked against an in-bench
// model or a typed-in reading. Depends on bvm_pkg and the channel interfaces in bvm_if.
`timescale 1ns / 1ps

module battery_voltage_monitor_unit_test;
   import bvm_pkg::*;

   localparam int ADC_W         = ADC_BITS_DEF;
   localparam int ADC_FULL      = (1 << ADC_W) - 1;
   localparam int NUM_SETTINGS  = 10;
   localparam int ITEMS_PER_SET = 78;
   localparam int SETTLE_CYCLES = 100;   // worst case is a transaction that detects a connect
   localparam int IDLE_LIMIT    = 4000;

   typedef struct packed {
      logic [VOLT_W-1:0]  voltage;
      bat_status_type     status;
      logic [CELLS_W-1:0] cells;
      logic [LEVEL_W-1:0] warn;
      logic [LEVEL_W-1:0] crit;
      beep_type           beep;
   } battery_reading_type;

   typedef struct packed {
      logic [ADC_W-1:0]    filtered;
      logic [ADC_W-1:0]    raw;
      bit                  known;     // reading below is typed in, not predicted
      battery_reading_type reading;
   } sample_vector_type;

   logic clock;
   logic reset;

   bvm_req_if #(.ADC_BITS(ADC_W)) req_bus();
   bvm_rsp_if                     rsp_bus();
   bvm_csr_if                     csr_bus();

   battery_voltage_monitor_unit #(.ADC_BITS(ADC_W)) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // Directed walk under the reset register values. With scale 110 and divider 10
   // the full-scale sample reads 36.3 V, which counts as eight cells (clamped from
   // nine) with pack levels 28.0 V and 26.4 V.
   sample_vector_type directed_vectors [0:18] = '{
      '{12'd0,    12'd0,    1'b1, '{14'd0,   ST_ABSENT, 4'd1, 9'd0,   9'd0,   BEEP_NONE}},
      '{12'hFFF,  12'hFFF,  1'b1, '{14'd363, ST_OK,     4'd8, 9'd280, 9'd264, BEEP_NONE}},
      '{12'hFFF,  12'd0,    1'b1, '{14'd363, ST_OK,     4'd8, 9'd280, 9'd264, BEEP_NONE}},
      '{12'd3176, 12'd0,    1'b0, '0},  // 28.2 V, ok holds
      '{12'd3165, 12'd0,    1'b0, '0},  // 28.1 V, ok still holds
      '{12'd3142, 12'd0,    1'b0, '0},  // 27.9 V, drop into warning
      '{12'd3165, 12'd0,    1'b0, '0},  // 28.1 V, inside hysteresis, warning stays
      '{12'd3176, 12'd0,    1'b0, '0},  // 28.2 V, back to ok
      '{12'd3142, 12'd0,    1'b0, '0},  // warning again
      '{12'd2962, 12'd0,    1'b0, '0},  // 26.3 V, critical
      '{12'd2984, 12'd0,    1'b0, '0},  // 26.5 V, critical stays
      '{12'd2996, 12'd0,    1'b0, '0},  // 26.6 V, back to warning
      '{12'd2000, 12'd0,    1'b0, '0},  // deep drop: one step only, to critical
      '{12'd0,    12'd0,    1'b1, '{14'd0,   ST_ABSENT, 4'd0, 9'd0,   9'd0,   BEEP_NONE}},
      '{12'd112,  12'hFFF,  1'b1, '{14'd10,  ST_ABSENT, 4'd0, 9'd0,   9'd0,   BEEP_NONE}},
      '{12'd124,  12'd0,    1'b0, '0},  // connect at 1.1 V with one cell, warning at once
      '{12'd112,  12'd0,    1'b1, '{14'd10,  ST_ABSENT, 4'd0, 9'd0,   9'd0,   BEEP_NONE}},
      '{12'hAAA,  12'h555,  1'b0, '0},  // alternating bits, connect with three cells
      '{12'h555,  12'hAAA,  1'b0, '0}
   };

   // Model copy of the registers and the monitor state
   logic [REG8_W-1:0]   cfg_scale;
   logic [REG8_W-1:0]   cfg_div;
   logic [REG8_W-1:0]   cfg_mult;
   logic [CELL_V_W-1:0] cfg_cell_max;
   logic [CELL_V_W-1:0] cfg_cell_warn;
   logic [CELL_V_W-1:0] cfg_cell_min;
   bat_status_type      mon_state;
   logic [CELLS_W-1:0]  cell_count;
   logic [LEVEL_W-1:0]  warn_level;
   logic [LEVEL_W-1:0]  crit_level;

   battery_reading_type expected_readings [$];

   int failures;
   int samples_sent;
   int readings_checked;
   int register_writes;
   int connects;
   int disconnects;
   int warn_entries;
   int crit_entries;
   int idle_cycles;

   // Free-running clock, 10 ns period
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic flag_failure(input string what);
      $display("%0t ns  mismatch: %s", $time, what);
      failures++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
      if (got !== want)
         flag_failure($sformatf("reading %0d %s got %0d want %0d", readings_checked, name,
                                got, want));
   endtask

   // Filtered or raw ADC code to 0.1 V steps, rounded; zero divisors act as one
   function automatic int adc_to_decivolts(input logic [ADC_W-1:0] code);
      longint dv;
      longint dm;
      longint v;
      dv = (cfg_div == 0) ? 1 : longint'(cfg_div);
      dm = (cfg_mult == 0) ? 1 : longint'(cfg_mult);
      v  = (longint'(code) * longint'(cfg_scale) * VREF_FACTOR + ADC_FULL * ROUND_FACTOR)
           / (ADC_FULL * dv);
      v  = v / dm;
      if (v > 16383) v = 16383;
      return int'(v);
   endfunction

   // Rough inverse of the conversion, used only to aim stimulus at a voltage
   function automatic logic [ADC_W-1:0] decivolts_to_adc(input int target);
      longint dv;
      longint dm;
      longint code;
      if (cfg_scale == 0) return ADC_W'($urandom_range(0, ADC_FULL));
      if (target <= 0) return '0;
      dv   = (cfg_div == 0) ? 1 : longint'(cfg_div);
      dm   = (cfg_mult == 0) ? 1 : longint'(cfg_mult);
      code = longint'(target) * ADC_FULL * dv * dm / (longint'(cfg_scale) * VREF_FACTOR);
      code = code + longint'($urandom_range(0, 2)) - 1;
      if (code < 0) code = 0;
      if (code > ADC_FULL) code = ADC_FULL;
      return ADC_W'(code);
   endfunction

   // Advance the monitor state by one sample and return the reading it gives
   function automatic battery_reading_type predict_reading(input logic [ADC_W-1:0] filt,
                                                           input logic [ADC_W-1:0] raw);
      battery_reading_type r;
      int volts;
      int cells_now;
      int lvl;
      beep_type beep;
      volts = adc_to_decivolts(filt);
      beep  = BEEP_NONE;

      if (mon_state == ST_ABSENT && volts > int'(PRESENT_LEVEL)) begin
         mon_state = ST_OK;
         connects++;
         if (cfg_cell_max == 0) begin
            cells_now = int'(MAX_CELLS);
         end else begin
            cells_now = adc_to_decivolts(raw) / int'(cfg_cell_max) + 1;
            if (cells_now > int'(MAX_CELLS)) cells_now = int'(MAX_CELLS);
         end
         cell_count = CELLS_W'(cells_now);
         lvl        = int'(cell_count) * int'(cfg_cell_warn);
         warn_level = (lvl > int'(LEVEL_MAX)) ? LEVEL_MAX : LEVEL_W'(lvl);
         lvl        = int'(cell_count) * int'(cfg_cell_min);
         crit_level = (lvl > int'(LEVEL_MAX)) ? LEVEL_MAX : LEVEL_W'(lvl);
      end else if (mon_state != ST_ABSENT && volts <= int'(PRESENT_LEVEL)) begin
         mon_state  = ST_ABSENT;
         disconnects++;
         cell_count = '0;
         warn_level = '0;
         crit_level = '0;
      end

      // Signed compares against level minus one: a zero level never trips
      case (mon_state)
         ST_OK: begin
            if (volts <= int'(warn_level) - HYST) begin
               mon_state = ST_WARN;
               beep      = BEEP_LOW;
               warn_entries++;
            end
         end
         ST_WARN: begin
            if (volts <= int'(crit_level) - HYST) begin
               mon_state = ST_CRIT;
               beep      = BEEP_CRIT;
               crit_entries++;
            end else if (volts > int'(warn_level) + HYST) begin
               mon_state = ST_OK;
            end else begin
               beep = BEEP_LOW;
            end
         end
         ST_CRIT: begin
            if (volts > int'(crit_level) + HYST) begin
               mon_state = ST_WARN;
               beep      = BEEP_LOW;
            end else begin
               beep = BEEP_CRIT;
            end
         end
         default: ;
      endcase

      r.voltage = VOLT_W'(volts);
      r.status  = mon_state;
      r.cells   = cell_count;
      r.warn    = warn_level;
      r.crit    = crit_level;
      r.beep    = beep;
      return r;
   endfunction

   // Present one sample, hold it until accepted, then record what it should give
   task automatic send_sample(input logic [ADC_W-1:0] filt, input logic [ADC_W-1:0] raw,
                              input bit known, input battery_reading_type known_reading);
      battery_reading_type predicted;
      @(negedge clock);
      req_bus.valid           = 1'b1;
      req_bus.filtered_sample = filt;
      req_bus.raw_sample      = raw;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predicted = predict_reading(filt, raw);
      expected_readings.push_back(known ? known_reading : predicted);
      samples_sent++;
   endtask

   // Drop valid and keep the sender quiet for a number of cycles
   task automatic pause_sender(input int cycles);
      @(negedge clock);
      req_bus.valid = 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic wait_for_readings();
      while (expected_readings.size() != 0) @(negedge clock);
   endtask

   task automatic write_register(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data  = data;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      case (idx)
         CSR_VOLTAGE_SCALE:        cfg_scale     = data;
         CSR_DIVIDER_VALUE:        cfg_div       = data;
         CSR_DIVIDER_MULTIPLIER:   cfg_mult      = data;
         CSR_CELL_MAX_VOLTAGE:     cfg_cell_max  = data[CELL_V_W-1:0];
         CSR_CELL_WARNING_VOLTAGE: cfg_cell_warn = data[CELL_V_W-1:0];
         CSR_CELL_MIN_VOLTAGE:     cfg_cell_min  = data[CELL_V_W-1:0];
         default: ;
      endcase
      register_writes++;
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // Register set for one phase of the run; the first few are the corners
   task automatic apply_setting(input int setting);
      case (setting)
         1: begin
            // largest scale, smallest divisors, 6-bit fields written with the upper bits set
            write_register(CSR_VOLTAGE_SCALE,        8'hFF);
            write_register(CSR_DIVIDER_VALUE,        8'd1);
            write_register(CSR_DIVIDER_MULTIPLIER,   8'd1);
            write_register(CSR_CELL_MAX_VOLTAGE,     8'hFF);
            write_register(CSR_CELL_WARNING_VOLTAGE, 8'hFF);
            write_register(CSR_CELL_MIN_VOLTAGE,     8'hFF);
         end
         2: begin
            // zero divisors act as one, zero cell voltage means full cell count,
            // zero levels never trip
            write_register(CSR_DIVIDER_VALUE,        8'd0);
            write_register(CSR_DIVIDER_MULTIPLIER,   8'd0);
            write_register(CSR_CELL_MAX_VOLTAGE,     8'd0);
            write_register(CSR_CELL_WARNING_VOLTAGE, 8'd0);
            write_register(CSR_CELL_MIN_VOLTAGE,     8'd0);
         end
         3: begin
            // zero scale: voltage never clears the presence level
            write_register(CSR_VOLTAGE_SCALE, 8'd0);
         end
         4: begin
            // smallest nonzero values: tiny voltages and one-step levels
            write_register(CSR_VOLTAGE_SCALE,        8'd1);
            write_register(CSR_DIVIDER_VALUE,        8'd1);
            write_register(CSR_DIVIDER_MULTIPLIER,   8'd1);
            write_register(CSR_CELL_MAX_VOLTAGE,     8'd1);
            write_register(CSR_CELL_WARNING_VOLTAGE, 8'd1);
            write_register(CSR_CELL_MIN_VOLTAGE,     8'd1);
         end
         5: begin
            write_register(CSR_VOLTAGE_SCALE,        SCALE_RESET);
            write_register(CSR_DIVIDER_VALUE,        DIV_VAL_RESET);
            write_register(CSR_DIVIDER_MULTIPLIER,   DIV_MULT_RESET);
            write_register(CSR_CELL_MAX_VOLTAGE,     CSR_DATA_W'(CELL_MAX_RESET));
            write_register(CSR_CELL_WARNING_VOLTAGE, CSR_DATA_W'(CELL_WARN_RESET));
            write_register(CSR_CELL_MIN_VOLTAGE,     CSR_DATA_W'(CELL_MIN_RESET));
         end
         default: begin
            // random subset with random contents; keep the divisors modest most of
            // the time so that the voltage range stays interesting
            for (int i = 0; i <= int'(CSR_CELL_MIN_VOLTAGE); i++) begin
               if ($urandom_range(0, 3) != 0) begin
                  if (i == int'(CSR_DIVIDER_VALUE) || i == int'(CSR_DIVIDER_MULTIPLIER))
                     write_register(csr_idx_type'(i),
                                    CSR_DATA_W'(($urandom_range(0, 3) == 0) ?
                                                $urandom_range(0, 255) :
                                                $urandom_range(0, 12)));
                  else
                     write_register(csr_idx_type'(i), CSR_DATA_W'($urandom_range(0, 255)));
               end
            end
         end
      endcase
   endtask

   // Random sample, mostly aimed at the presence, warning and critical edges
   task automatic send_random_sample();
      logic [ADC_W-1:0] filt;
      logic [ADC_W-1:0] raw;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 12)
         filt = ADC_W'($urandom_range(0, ADC_FULL));
      else if (pick < 20)
         filt = decivolts_to_adc($urandom_range(0, 10));
      else if (pick < 32)
         filt = decivolts_to_adc(int'(PRESENT_LEVEL) + int'($urandom_range(0, 4)) - 2);
      else if (mon_state == ST_ABSENT)
         filt = decivolts_to_adc($urandom_range(11, 600));
      else if (pick < 66)
         filt = decivolts_to_adc(int'(warn_level) + int'($urandom_range(0, 6)) - 3);
      else
         filt = decivolts_to_adc(int'(crit_level) + int'($urandom_range(0, 6)) - 3);

      pick = $urandom_range(0, 99);
      if (pick < 60)
         raw = ADC_W'($urandom_range(0, ADC_FULL));
      else if (pick < 70)
         raw = '0;
      else if (pick < 80)
         raw = '1;
      else  // straddle a cell-count boundary
         raw = decivolts_to_adc(int'(cfg_cell_max) * int'($urandom_range(0, 9))
                                + int'($urandom_range(0, 2)) - 1);
      send_sample(filt, raw, 1'b0, '0);
   endtask

   // Response side: stall on a rotating 16-bit pattern, reselected after every four full rotations
   initial begin
      logic [15:0] pattern;
      int          pick;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         pick = $urandom_range(0, 3);
         case (pick)
            0:       pattern = '1;
            1:       pattern = 16'($urandom);
            2:       pattern = 16'($urandom) & 16'($urandom);
            default: pattern = 16'($urandom) | 16'($urandom);
         endcase
         if (pattern == 0) pattern = 16'h0001;
         repeat (64) begin
            rsp_bus.ready = pattern[0];
            pattern       = {pattern[0], pattern[15:1]};
            @(negedge clock);
         end
      end
   end

   // Check every response transaction against the oldest outstanding expected reading
   always @(posedge clock) begin
      battery_reading_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (expected_readings.size() == 0) begin
            flag_failure("response transaction with no sample outstanding");
         end else begin
            want = expected_readings.pop_front();
            check_field("voltage",            16'(rsp_bus.voltage),            16'(want.voltage));
            check_field("battery_status",     16'(rsp_bus.battery_status),     16'(want.status));
            check_field("cells",              16'(rsp_bus.cells),              16'(want.cells));
            check_field("warning_threshold",  16'(rsp_bus.warning_threshold),  16'(want.warn));
            check_field("critical_threshold", 16'(rsp_bus.critical_threshold), 16'(want.crit));
            check_field("beep_request",       16'(rsp_bus.beep_request),       16'(want.beep));
         end
         readings_checked++;
      end
   end

   // Watchdog: end the run if no channel moves a transaction for too long
   always @(posedge clock) begin
      if (reset || (req_bus.valid === 1'b1 && req_bus.ready === 1'b1)
                || (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
                || (csr_bus.valid === 1'b1 && csr_bus.ready === 1'b1))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Watchdog: no transaction for %0d cycles, %0d readings still outstanding",
                  IDLE_LIMIT, expected_readings.size());
         $display("[battery_voltage_monitor_unit] ERROR");
         $finish;
      end
   end

   // Main sequence: reset, directed table, then random phases between register changes
   initial begin
      int burst_left;
      int gap;

      reset                   = 1'b1;
      req_bus.valid           = 1'b0;
      req_bus.filtered_sample = '0;
      req_bus.raw_sample      = '0;
      csr_bus.valid           = 1'b0;
      csr_bus.index           = CSR_VOLTAGE_SCALE;
      csr_bus.data            = '0;
      idle_cycles             = 0;
      failures                = 0;
      samples_sent            = 0;
      readings_checked        = 0;
      register_writes         = 0;
      connects                = 0;
      disconnects             = 0;
      warn_entries            = 0;
      crit_entries            = 0;

      cfg_scale     = SCALE_RESET;
      cfg_div       = DIV_VAL_RESET;
      cfg_mult      = DIV_MULT_RESET;
      cfg_cell_max  = CELL_MAX_RESET;
      cfg_cell_warn = CELL_WARN_RESET;
      cfg_cell_min  = CELL_MIN_RESET;
      mon_state     = ST_ABSENT;
      cell_count    = CELLS_RESET;
      warn_level    = '0;
      crit_level    = '0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int setting = 0; setting < NUM_SETTINGS; setting++) begin
         if (setting == 0) begin
            // back-to-back directed samples, then hold off until all have come back
            foreach (directed_vectors[i])
               send_sample(directed_vectors[i].filtered, directed_vectors[i].raw,
                           directed_vectors[i].known, directed_vectors[i].reading);
            pause_sender(1);
            wait_for_readings();
         end else begin
            // registers change only with nothing in flight
            pause_sender(1);
            wait_for_readings();
            repeat (SETTLE_CYCLES) @(negedge clock);
            apply_setting(setting);
         end

         burst_left = 0;
         for (int n = 0; n < ITEMS_PER_SET; n++) begin
            if (burst_left == 0) begin
               // new burst; a quarter of the bursts follow the last one with no gap
               burst_left = $urandom_range(1, 24);
               gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               if (gap != 0) pause_sender(gap);
            end
            // once mid-phase, let the pipeline empty completely before going on
            if (setting == 6 && n == ITEMS_PER_SET / 2) begin
               pause_sender(1);
               wait_for_readings();
            end
            send_random_sample();
            burst_left--;
         end
      end

      // drain: everything back, then a quiet spell of SETTLE_CYCLES to catch strays
      pause_sender(1);
      wait_for_readings();
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Covered %0d samples over %0d register settings (%0d register writes).",
               samples_sent, NUM_SETTINGS, register_writes);
      $display("Saw %0d connects, %0d disconnects, %0d warning and %0d critical entries.",
               connects, disconnects, warn_entries, crit_entries);
      if (failures == 0) begin
         $display("[battery_voltage_monitor_unit] OK");
      end else begin
         $display("%0d mismatches in %0d readings checked", failures, readings_checked);
         $display("[battery_voltage_monitor_unit] ERROR");
      end
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/bvm_pkg.sv
hw/rtl/bvm_if.sv
hw/rtl/bvm_divider.sv
hw/rtl/bvm_datapath.sv
hw/rtl/bvm_ctrl.sv
hw/rtl/battery_voltage_monitor_unit.sv
test/battery_voltage_monitor_unit_test.sv
